// ----- rtl/i2c_mbe_pkg.sv -----
package i2c_mbe_pkg;

    // Mode codes as they arrive on the input channel
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    // Bit group index of the acknowledge slot; byte commands run nine groups
    localparam logic [3:0] ACK_GROUP      = 4'd8;
    localparam logic [3:0] BYTE_GROUPS    = 4'd9;
    localparam logic [3:0] SINGLE_GROUPS  = 4'd1;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd50;

    typedef enum logic [4:0] {
        CMD_IDLE  = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP  = 5'b00100,
        CMD_WRITE = 5'b01000,
        CMD_READ  = 5'b10000
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } result_t;

endpackage

// ----- rtl/i2c_mbe_in_reg.sv -----
module i2c_mbe_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2c_mbe_pkg::item_t  s_item,
    input  logic                advance,
    output logic                item_valid,
    output i2c_mbe_pkg::item_t  item
);

    logic               valid_reg;
    i2c_mbe_pkg::item_t item_reg;

    // Slot frees up in the same cycle the engine consumes it
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- rtl/i2c_mbe_engine.sv -----
module i2c_mbe_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  i2c_mbe_pkg::item_t      item,
    input  logic [7:0]              phase_ticks,
    output i2c_mbe_pkg::result_t    result
);

    i2c_mbe_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0] step_reg, step_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_reg, tick_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_reg, ack_next;
    logic [7:0] rx_reg, rx_next;
    logic       reply_reg, reply_next;
    logic       done;
    logic [7:0] limit;
    logic [1:0] phases;
    logic [3:0] groups;
    logic [1:0] drv;

    // Line drives set on entry to a phase; returns {scl, sda}
    function automatic logic [1:0] enter_drive(
        input i2c_mbe_pkg::cmd_t c,
        input logic [1:0]        ph,
        input logic [3:0]        bc,
        input logic [7:0]        sh,
        input logic              rep,
        input logic              scl,
        input logic              sda
    );
        logic s_cl;
        logic s_da;
        s_cl = scl;
        s_da = sda;
        unique case (c)
            i2c_mbe_pkg::CMD_START: begin
                if (ph == 2'd0) begin
                    s_da = 1'b1;
                    s_cl = 1'b1;
                end else if (ph == 2'd1) begin
                    s_da = 1'b0;
                end else begin
                    s_cl = 1'b0;
                end
            end
            i2c_mbe_pkg::CMD_STOP: begin
                if (ph == 2'd0) s_da = 1'b0;
                else if (ph == 2'd1) s_cl = 1'b1;
                else s_da = 1'b1;
            end
            i2c_mbe_pkg::CMD_WRITE: begin
                if (ph == 2'd0) s_da = (bc < i2c_mbe_pkg::ACK_GROUP) ? sh[7] : 1'b1;
                else if (ph == 2'd1) s_cl = 1'b1;
                else s_cl = 1'b0;
            end
            i2c_mbe_pkg::CMD_READ: begin
                if (bc < i2c_mbe_pkg::ACK_GROUP) begin
                    s_cl = (ph == 2'd0);
                end else if (ph == 2'd0) begin
                    s_da = !rep;
                end else if (ph == 2'd1) begin
                    s_cl = 1'b1;
                end else begin
                    s_cl = 1'b0;
                end
            end
            default: ;
        endcase
        return {s_cl, s_da};
    endfunction

    assign limit = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

    always_comb begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        reply_next = reply_reg;
        done       = 1'b0;
        phases     = 2'd3;
        groups     = i2c_mbe_pkg::SINGLE_GROUPS;
        drv        = 2'b11;

        if (cmd_reg == i2c_mbe_pkg::CMD_IDLE) begin
            unique case (item.mode)
                i2c_mbe_pkg::MODE_START: cmd_next = i2c_mbe_pkg::CMD_START;
                i2c_mbe_pkg::MODE_STOP:  cmd_next = i2c_mbe_pkg::CMD_STOP;
                i2c_mbe_pkg::MODE_WRITE: begin
                    cmd_next   = i2c_mbe_pkg::CMD_WRITE;
                    shift_next = item.tx_byte;
                end
                i2c_mbe_pkg::MODE_READ: begin
                    cmd_next   = i2c_mbe_pkg::CMD_READ;
                    shift_next = 8'd0;
                    reply_next = item.send_ack;
                    sda_next   = 1'b1;
                end
                default: ;
            endcase
            if (cmd_next != i2c_mbe_pkg::CMD_IDLE) begin
                step_next = 2'd0;
                bit_next  = 4'd0;
                drv = enter_drive(cmd_next, 2'd0, 4'd0, shift_next, reply_next,
                                  scl_reg, sda_next);
                scl_next  = drv[1];
                sda_next  = drv[0];
                tick_next = 8'd1;
            end
        end else if (tick_reg >= limit) begin
            // Samples taken as the phase closes
            if (cmd_reg == i2c_mbe_pkg::CMD_WRITE) begin
                if (bit_reg < i2c_mbe_pkg::ACK_GROUP && step_reg == 2'd2) begin
                    shift_next = {shift_reg[6:0], 1'b0};
                end else if (bit_reg == i2c_mbe_pkg::ACK_GROUP && step_reg == 2'd1) begin
                    ack_next = item.sda_level;
                end
            end else if (cmd_reg == i2c_mbe_pkg::CMD_READ) begin
                if (bit_reg < i2c_mbe_pkg::ACK_GROUP && step_reg == 2'd0) begin
                    shift_next = {shift_reg[6:0], item.sda_level};
                end
            end

            if (cmd_reg == i2c_mbe_pkg::CMD_READ && bit_reg < i2c_mbe_pkg::ACK_GROUP) begin
                phases = 2'd2;
            end
            if (cmd_reg == i2c_mbe_pkg::CMD_WRITE || cmd_reg == i2c_mbe_pkg::CMD_READ) begin
                groups = i2c_mbe_pkg::BYTE_GROUPS;
            end

            step_next = step_reg + 2'd1;
            if (step_next >= phases) begin
                step_next = 2'd0;
                bit_next  = bit_reg + 4'd1;
            end

            if (bit_next >= groups) begin
                if (cmd_reg == i2c_mbe_pkg::CMD_READ) begin
                    sda_next = 1'b1;
                    rx_next  = shift_next;
                end
                cmd_next  = i2c_mbe_pkg::CMD_IDLE;
                step_next = 2'd0;
                bit_next  = 4'd0;
                tick_next = 8'd0;
                done      = 1'b1;
            end else begin
                drv = enter_drive(cmd_reg, step_next, bit_next, shift_next, reply_reg,
                                  scl_reg, sda_reg);
                scl_next  = drv[1];
                sda_next  = drv[0];
                tick_next = 8'd1;
            end
        end else begin
            tick_next = tick_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= i2c_mbe_pkg::CMD_IDLE;
            step_reg  <= 2'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            tick_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
            reply_reg <= 1'b0;
        end else if (advance) begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
            reply_reg <= reply_next;
        end
    end

    assign result.scl_out   = scl_next;
    assign result.sda_out   = sda_next;
    assign result.busy_res  = (cmd_next != i2c_mbe_pkg::CMD_IDLE);
    assign result.done_res  = done;
    assign result.rx_byte   = rx_next;
    assign result.nack_seen = ack_next;

endmodule

// ----- rtl/i2c_master_byte_engine_core.sv -----
// I2C master byte engine: bit-level open-drain master for START, STOP,
// write-byte and read-byte commands. Each transfer on the s_ channel is one
// time tick carrying an optional command (s_mode) and the sampled SDA level;
// each tick yields exactly one transfer on the m_ channel with the SCL/SDA
// drives, busy/done flags, last received byte and the write NACK flag.
// Bus phases last cfg_wdata ticks as written through cfg_we (zero acts as
// one); write it only while the engine is idle.
// A tick accepted on the s_ channel passes the input register, then the result
// register, before the m_ channel offers it. Throughput: one tick per clock
// unless m_ready stalls, set by the single next-state pass between registers.
// Commands arriving while a command runs are dropped.
// Reset (aresetn low, synchronous) releases both lines, clears all flags,
// empties both registers and loads a phase length of 50 ticks.
// When m_ready is low the result register holds; the input register takes
// one more tick, then s_ready drops until the result is taken, so the bus
// timing simply pauses without loss.
module i2c_master_byte_engine_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_byte,
    output logic       m_nack_seen
);

    logic [7:0]           phase_ticks_reg;
    logic                 m_valid_reg;
    i2c_mbe_pkg::result_t res_reg;
    i2c_mbe_pkg::result_t res_next;
    i2c_mbe_pkg::item_t   s_item;
    i2c_mbe_pkg::item_t   item;
    logic                 item_valid;
    logic                 advance;

    assign s_item.mode      = s_mode;
    assign s_item.tx_byte   = s_tx_byte;
    assign s_item.send_ack  = s_send_ack;
    assign s_item.sda_level = s_sda_level;

    assign advance = item_valid && (!m_valid_reg || m_ready);

    i2c_mbe_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2c_mbe_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (item),
        .phase_ticks (phase_ticks_reg),
        .result      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2c_mbe_pkg::PHASE_TICKS_RST;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_out   = res_reg.scl_out;
    assign m_sda_out   = res_reg.sda_out;
    assign m_busy_res  = res_reg.busy_res;
    assign m_done_res  = res_reg.done_res;
    assign m_rx_byte   = res_reg.rx_byte;
    assign m_nack_seen = res_reg.nack_seen;

endmodule

// ----- bench/i2c_byte_checker.sv -----
module i2c_byte_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_level,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_scl_out,
    input  logic       m_sda_out,
    input  logic       m_busy_res,
    input  logic       m_done_res,
    input  logic [7:0] m_rx_byte,
    input  logic       m_nack_seen,
    output int         fail_count,
    output int         pending
);

    i2c_mbe_pkg::result_t bus_state_q[$];
    int                   n_results;

    // engine state as the bus master should hold it
    i2c_mbe_pkg::cmd_t held;
    logic [4:0]        step;
    logic [3:0]        group;
    logic [7:0]        shreg;
    logic [7:0]        ticks;
    logic [7:0]        phase_len;
    logic [7:0]        rx_q;
    logic              scl_q;
    logic              sda_q;
    logic              ack_q;
    logic              reply_q;

    task automatic flag_mismatch(input string msg);
        $display("checker: result %0d: %s", n_results, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
        end
    endtask

    // line drives on entry to the current phase
    function void set_phase_drives();
        case (held)
            i2c_mbe_pkg::CMD_START: begin
                if (step == 0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else if (step == 1) begin
                    sda_q = 1'b0;
                end else begin
                    scl_q = 1'b0;
                end
            end
            i2c_mbe_pkg::CMD_STOP: begin
                if (step == 0) sda_q = 1'b0;
                else if (step == 1) scl_q = 1'b1;
                else sda_q = 1'b1;
            end
            i2c_mbe_pkg::CMD_WRITE: begin
                if (step == 0) sda_q = (group < i2c_mbe_pkg::ACK_GROUP) ? shreg[7] : 1'b1;
                else if (step == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            i2c_mbe_pkg::CMD_READ: begin
                if (group < i2c_mbe_pkg::ACK_GROUP) begin
                    scl_q = (step == 0);
                end else if (step == 0) begin
                    sda_q = !reply_q;
                end else if (step == 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic i2c_mbe_pkg::result_t advance_tick(input i2c_mbe_pkg::item_t it);
        logic [7:0]           lim;
        logic                 done;
        i2c_mbe_pkg::result_t r;
        lim  = (phase_len == 0) ? 8'd1 : phase_len;
        done = 1'b0;
        if (held == i2c_mbe_pkg::CMD_IDLE) begin
            if (it.mode >= i2c_mbe_pkg::MODE_START && it.mode <= i2c_mbe_pkg::MODE_READ) begin
                case (it.mode)
                    i2c_mbe_pkg::MODE_START: held = i2c_mbe_pkg::CMD_START;
                    i2c_mbe_pkg::MODE_STOP:  held = i2c_mbe_pkg::CMD_STOP;
                    i2c_mbe_pkg::MODE_WRITE: held = i2c_mbe_pkg::CMD_WRITE;
                    default:                 held = i2c_mbe_pkg::CMD_READ;
                endcase
                step  = '0;
                group = '0;
                if (it.mode == i2c_mbe_pkg::MODE_WRITE) begin
                    shreg = it.tx_byte;
                end else if (it.mode == i2c_mbe_pkg::MODE_READ) begin
                    shreg   = '0;
                    reply_q = it.send_ack;
                    sda_q   = 1'b1;
                end
                set_phase_drives();
                ticks = 8'd1;
            end
        end else if (ticks >= lim) begin
            // samples are taken on the tick that closes a phase
            if (held == i2c_mbe_pkg::CMD_WRITE) begin
                if (group < i2c_mbe_pkg::ACK_GROUP && step == 2) begin
                    shreg = shreg << 1;
                end else if (group == i2c_mbe_pkg::ACK_GROUP && step == 1) begin
                    ack_q = it.sda_level;
                end
            end else if (held == i2c_mbe_pkg::CMD_READ && group < i2c_mbe_pkg::ACK_GROUP
                         && step == 0) begin
                shreg = {shreg[6:0], it.sda_level};
            end
            step++;
            if (step >= ((held == i2c_mbe_pkg::CMD_READ && group < i2c_mbe_pkg::ACK_GROUP)
                         ? 2 : 3)) begin
                step = '0;
                group++;
            end
            if (group >= ((held == i2c_mbe_pkg::CMD_WRITE || held == i2c_mbe_pkg::CMD_READ)
                          ? i2c_mbe_pkg::BYTE_GROUPS : i2c_mbe_pkg::SINGLE_GROUPS)) begin
                if (held == i2c_mbe_pkg::CMD_READ) begin
                    sda_q = 1'b1;
                    rx_q  = shreg;
                end
                held  = i2c_mbe_pkg::CMD_IDLE;
                step  = '0;
                group = '0;
                ticks = '0;
                done  = 1'b1;
            end else begin
                set_phase_drives();
                ticks = 8'd1;
            end
        end else begin
            ticks++;
        end
        r.scl_out   = scl_q;
        r.sda_out   = sda_q;
        r.busy_res  = (held != i2c_mbe_pkg::CMD_IDLE);
        r.done_res  = done;
        r.rx_byte   = rx_q;
        r.nack_seen = ack_q;
        return r;
    endfunction

    always @(posedge aclk) begin
        i2c_mbe_pkg::item_t   it;
        i2c_mbe_pkg::result_t want;
        if (!aresetn) begin
            bus_state_q.delete();
            held      = i2c_mbe_pkg::CMD_IDLE;
            step      = '0;
            group     = '0;
            shreg     = '0;
            ticks     = '0;
            phase_len = i2c_mbe_pkg::PHASE_TICKS_RST;
            rx_q      = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            ack_q     = 1'b0;
            reply_q   = 1'b0;
        end else begin
            if (cfg_we) phase_len = cfg_wdata;
            if (s_valid && s_ready) begin
                it.mode      = s_mode;
                it.tx_byte   = s_tx_byte;
                it.send_ack  = s_send_ack;
                it.sda_level = s_sda_level;
                bus_state_q.push_back(advance_tick(it));
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (bus_state_q.size() == 0) begin
                    flag_mismatch("transfer out with nothing outstanding");
                end else begin
                    want = bus_state_q.pop_front();
                    check_field("scl_out", 8'(m_scl_out), 8'(want.scl_out));
                    check_field("sda_out", 8'(m_sda_out), 8'(want.sda_out));
                    check_field("busy_res", 8'(m_busy_res), 8'(want.busy_res));
                    check_field("done_res", 8'(m_done_res), 8'(want.done_res));
                    check_field("rx_byte", m_rx_byte, want.rx_byte);
                    check_field("nack_seen", 8'(m_nack_seen), 8'(want.nack_seen));
                end
            end
        end
        pending = bus_state_q.size();
    end

endmodule

// ----- bench/tb.sv -----
module tb;

    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         WRITE_PHASES   = 27;
    localparam int         READ_PHASES    = 19;
    localparam int         COND_PHASES    = 3;
    localparam int         TICKS_PER_STEP = 20;
    localparam logic [2:0] MODE_MAX       = 3'd7;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [7:0] cfg_wdata   = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [2:0] s_mode      = i2c_mbe_pkg::MODE_NONE;
    logic [7:0] s_tx_byte   = '0;
    logic       s_send_ack  = 1'b0;
    logic       s_sda_level = 1'b1;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_scl_out;
    logic       m_sda_out;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_rx_byte;
    logic       m_nack_seen;

    int         fail_count;
    int         pending;
    int         ticks_sent;
    int         cmds_sent;
    int         cycles;
    bit         calm;
    logic [7:0] cur_len = i2c_mbe_pkg::PHASE_TICKS_RST;
    logic [7:0] sweep_lens [6] = '{8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1};

    always #5 aclk = ~aclk;

    i2c_master_byte_engine_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_tx_byte   (s_tx_byte),
        .s_send_ack  (s_send_ack),
        .s_sda_level (s_sda_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rx_byte   (m_rx_byte),
        .m_nack_seen (m_nack_seen)
    );

    i2c_byte_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_tx_byte   (s_tx_byte),
        .s_send_ack  (s_send_ack),
        .s_sda_level (s_sda_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rx_byte   (m_rx_byte),
        .m_nack_seen (m_nack_seen),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 10);
    end

    // one bus tick; returns at the edge where the transfer happens
    task automatic send_tick(input logic [2:0] md, input logic [7:0] tx, input logic ack);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= md;
        s_tx_byte   <= tx;
        s_send_ack  <= ack;
        s_sda_level <= 1'($urandom_range(1));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    // command tick, then exactly enough ticks to reach the finishing tick;
    // stray commands in between must be dropped by the engine
    task automatic run_cmd(input logic [2:0] md, input logic [7:0] tx, input logic ack);
        int span;
        span = (md == i2c_mbe_pkg::MODE_WRITE) ? WRITE_PHASES
             : (md == i2c_mbe_pkg::MODE_READ) ? READ_PHASES : COND_PHASES;
        span = span * ((cur_len == 0) ? 1 : int'(cur_len));
        send_tick(md, tx, ack);
        cmds_sent++;
        for (int k = 1; k <= span; k++) begin
            send_tick((k == span || $urandom_range(7) == 0)
                      ? 3'($urandom_range(i2c_mbe_pkg::MODE_NONE, MODE_MAX))
                      : i2c_mbe_pkg::MODE_NONE,
                      8'($urandom), 1'($urandom_range(1)));
        end
        repeat ($urandom_range(2)) begin
            send_tick($urandom_range(1)
                      ? 3'($urandom_range(i2c_mbe_pkg::MODE_READ + 1, MODE_MAX))
                      : i2c_mbe_pkg::MODE_NONE,
                      8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic set_phase_len(input logic [7:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_len = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int mark;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase length straight out of reset
        run_cmd(i2c_mbe_pkg::MODE_START, 8'h00, 1'b0);

        // zero acts as one tick per phase
        set_phase_len(8'd0);
        run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'h00, 1'b0);
        run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'hFF, 1'b1);
        run_cmd(i2c_mbe_pkg::MODE_READ, 8'hFF, 1'b1);
        run_cmd(i2c_mbe_pkg::MODE_READ, 8'h00, 1'b0);
        run_cmd(i2c_mbe_pkg::MODE_STOP, 8'hFF, 1'b1);
        // SCL still released after the stop
        run_cmd(i2c_mbe_pkg::MODE_WRITE, 8'h5A, 1'b0);
        run_cmd(i2c_mbe_pkg::MODE_STOP, 8'h00, 1'b0);
        run_cmd(i2c_mbe_pkg::MODE_READ, 8'hA5, 1'b1);
        send_tick(MODE_MAX, 8'hFF, 1'b1);
        send_tick(3'(i2c_mbe_pkg::MODE_READ + 1), 8'h00, 1'b0);

        for (int i = 0; i < 6; i++) begin
            set_phase_len(sweep_lens[i]);
            calm = (i == 3);
            mark = ticks_sent;
            while (ticks_sent - mark < TICKS_PER_STEP) begin
                if ($urandom_range(4) != 0) begin
                    run_cmd(i2c_mbe_pkg::MODE_START, 8'($urandom), 1'($urandom_range(1)));
                    repeat ($urandom_range(1, 3)) begin
                        run_cmd($urandom_range(1) ? i2c_mbe_pkg::MODE_WRITE
                                                  : i2c_mbe_pkg::MODE_READ,
                                8'($urandom), 1'($urandom_range(1)));
                    end
                    run_cmd(i2c_mbe_pkg::MODE_STOP, 8'($urandom), 1'($urandom_range(1)));
                end else begin
                    run_cmd(3'($urandom_range(i2c_mbe_pkg::MODE_START,
                                              i2c_mbe_pkg::MODE_READ)),
                            8'($urandom), 1'($urandom_range(1)));
                end
            end
        end
        calm = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("summary: %0d ticks, %0d commands, phase lengths 0, 1, 2 and 50", ticks_sent,
                 cmds_sent);
        $display("summary: stray and mistimed commands mixed in, both channels stalled");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
